// File: rtl/core/co2p_pkg.sv
// Package: shared widths, command, status and register codes for the CO2 line parser.
`default_nettype none

package co2p_pkg;

    localparam int unsigned CMD_W     = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned PPM_W     = 16;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MAX_PPM = 1'b1;

    localparam logic [PPM_W-1:0]     MAX_PPM_RESET = 16'd10000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 17'h1FFFF;
    localparam logic [PPM_W-1:0]     PPM_SAT       = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

endpackage

`default_nettype wire

// File: rtl/core/co2p_if.sv
// Interfaces: command word channel and result word channel with valid/ready.
`default_nettype none

interface co2p_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [co2p_pkg::CMD_W-1:0]        command;
    logic [co2p_pkg::BYTE_W-1:0]       rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface co2p_res_if;
    logic                              valid;
    logic                              ready;
    logic [co2p_pkg::STATUS_W-1:0]     status;
    logic [co2p_pkg::PPM_W-1:0]        ppm;

    modport source (output valid, output status, output ppm, input ready);
    modport sink   (input valid, input status, input ppm, output ready);
endinterface

`default_nettype wire

// File: rtl/core/co2_ppm_line_parser.sv
// A word accepted into the input register passes the update stage into the result register.
// Throughput: one command word per cycle while the result word is not stalled; set by the single update stage
//   between the input register and the result register.
// Output stall holds the result register and backs up into the input register.
// Reset (synchronous, active low): idle, line cleared, timeout 0, max_ppm 10000.
// Timeout of zero selects the default limit; ticks beyond the limit close a request.
`default_nettype none

module co2_ppm_line_parser #(
    parameter int unsigned LINE_LIMIT         = 49,
    parameter int unsigned MIN_LINE           = 11,
    parameter int unsigned DEFAULT_TIMEOUT_MS = 3000
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    co2p_cmd_if.sink                           i_cmd,
    co2p_res_if.source                         o_res,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [co2p_pkg::APB_AW-1:0]   i_paddr,
    input  wire logic [co2p_pkg::APB_DW-1:0]   i_pwdata,
    output logic      [co2p_pkg::APB_DW-1:0]   o_prdata,
    output logic                               o_pready
);
    import co2p_pkg::*;

    // wide enough for a line limit and minimum length up to 63
    localparam int unsigned LEN_W = 6;
    localparam logic [LEN_W-1:0] LIMIT_L = LEN_W'(LINE_LIMIT);
    localparam logic [LEN_W-1:0] MIN_L   = LEN_W'(MIN_LINE);
    localparam logic [PPM_W-1:0] DEF_TO  = PPM_W'(DEFAULT_TIMEOUT_MS);

    // configuration
    logic [PPM_W-1:0] r_timeout_ms;
    logic [PPM_W-1:0] r_max_ppm;
    logic             cfg_wr;

    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= '0;
            r_max_ppm    <= MAX_PPM_RESET;
        end else if (cfg_wr) begin
            if (i_paddr[2] == REG_TIMEOUT) begin
                r_timeout_ms <= i_pwdata[PPM_W-1:0];
            end else begin
                r_max_ppm <= i_pwdata[PPM_W-1:0];
            end
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_paddr[2] == REG_TIMEOUT) begin
            o_prdata[PPM_W-1:0] = r_timeout_ms;
        end else begin
            o_prdata[PPM_W-1:0] = r_max_ppm;
        end
    end

    // input register
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_in_cmd;
    logic [BYTE_W-1:0] r_in_byte;
    logic              advance;

    assign advance     = !o_res.valid || o_res.ready;
    assign i_cmd.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_cmd  <= i_cmd.command;
            r_in_byte <= i_cmd.rx_byte;
        end
    end

    // request and line state
    logic                 r_busy;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     r_len_zero;
    logic                 r_zero_seen;
    logic                 r_digit_found;
    logic                 r_in_run;
    logic [PPM_W-1:0]     r_number;
    logic                 r_last_cr;

    logic                 n_busy;
    logic [ELAPSED_W-1:0] n_elapsed;
    logic [LEN_W-1:0]     n_len;
    logic [LEN_W-1:0]     n_len_zero;
    logic                 n_zero_seen;
    logic                 n_digit_found;
    logic                 n_in_run;
    logic [PPM_W-1:0]     n_number;
    logic                 n_last_cr;

    // state after storing the byte
    logic [LEN_W-1:0]     u_len;
    logic [LEN_W-1:0]     u_len_zero;
    logic                 u_zero_seen;
    logic                 u_digit_found;
    logic                 u_in_run;
    logic [PPM_W-1:0]     u_number;

    // line being checked
    logic [LEN_W-1:0]     f_len;
    logic [LEN_W-1:0]     f_eff;
    logic                 f_cr;
    logic                 f_digit;
    logic [PPM_W-1:0]     f_number;
    logic                 f_good;

    logic                 is_lf;
    logic                 is_digit;
    logic [3:0]           digit;
    logic [PPM_W+3:0]     acc;
    logic                 finish;
    logic [PPM_W-1:0]     limit;

    logic                 n_res_valid;
    logic [STATUS_W-1:0]  n_status;
    logic [PPM_W-1:0]     n_ppm;

    always_comb begin
        is_lf    = (r_in_byte == CHAR_LF);
        is_digit = (r_in_byte >= CHAR_ZERO) && (r_in_byte <= CHAR_NINE);
        digit    = 4'(r_in_byte - CHAR_ZERO);
        acc      = ({4'b0, r_number} << 3) + ({4'b0, r_number} << 1) + (PPM_W+4)'(digit);
        limit    = (r_timeout_ms == '0) ? DEF_TO : r_timeout_ms;

        u_len         = r_len + 1'b1;
        u_len_zero    = r_len_zero;
        u_zero_seen   = r_zero_seen;
        u_digit_found = r_digit_found;
        u_in_run      = r_in_run;
        u_number      = r_number;
        if (!r_zero_seen) begin
            if (r_in_byte == CHAR_NUL) begin
                u_zero_seen = 1'b1;
                u_len_zero  = r_len;
                u_in_run    = 1'b0;
            end else if (is_digit) begin
                if (!r_digit_found) begin
                    u_digit_found = 1'b1;
                    u_in_run      = 1'b1;
                    u_number      = PPM_W'(digit);
                end else if (r_in_run) begin
                    u_number = (acc > (PPM_W+4)'(PPM_SAT)) ? PPM_SAT : acc[PPM_W-1:0];
                end
            end else begin
                u_in_run = 1'b0;
            end
        end

        // newline checks the line as it stands; a full line is checked after the byte
        if (is_lf) begin
            f_len    = r_len;
            f_eff    = r_zero_seen ? r_len_zero : r_len;
            f_cr     = r_last_cr;
            f_digit  = r_digit_found;
            f_number = r_number;
        end else begin
            f_len    = u_len;
            f_eff    = u_zero_seen ? u_len_zero : u_len;
            f_cr     = (r_in_byte == CHAR_CR);
            f_digit  = u_digit_found;
            f_number = u_number;
        end
        f_good = (f_len != '0) && (f_eff >= MIN_L) && f_cr && f_digit;
        finish = is_lf || (u_len >= LIMIT_L);

        n_busy        = r_busy;
        n_elapsed     = r_elapsed;
        n_len         = r_len;
        n_len_zero    = r_len_zero;
        n_zero_seen   = r_zero_seen;
        n_digit_found = r_digit_found;
        n_in_run      = r_in_run;
        n_number      = r_number;
        n_last_cr     = r_last_cr;
        n_res_valid   = 1'b0;
        n_status      = ST_OK;
        n_ppm         = '0;

        unique case (t_cmd'(r_in_cmd))
            CMD_START: begin
                n_busy        = 1'b1;
                n_elapsed     = '0;
                n_len         = '0;
                n_len_zero    = '0;
                n_zero_seen   = 1'b0;
                n_digit_found = 1'b0;
                n_in_run      = 1'b0;
                n_number      = '0;
                n_last_cr     = 1'b0;
            end
            CMD_BYTE: begin
                if (r_busy) begin
                    if (finish) begin
                        n_len         = '0;
                        n_len_zero    = '0;
                        n_zero_seen   = 1'b0;
                        n_digit_found = 1'b0;
                        n_in_run      = 1'b0;
                        n_number      = '0;
                        n_last_cr     = 1'b0;
                        if (f_good) begin
                            n_busy      = 1'b0;
                            n_res_valid = 1'b1;
                            if (f_number <= r_max_ppm) begin
                                n_status = ST_OK;
                                n_ppm    = f_number;
                            end else begin
                                n_status = ST_INVALID;
                            end
                        end
                    end else begin
                        n_len         = u_len;
                        n_len_zero    = u_len_zero;
                        n_zero_seen   = u_zero_seen;
                        n_digit_found = u_digit_found;
                        n_in_run      = u_in_run;
                        n_number      = u_number;
                        n_last_cr     = (r_in_byte == CHAR_CR);
                    end
                end
            end
            CMD_TICK: begin
                if (r_busy) begin
                    if (r_elapsed != ELAPSED_MAX) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                    if (n_elapsed > {1'b0, limit}) begin
                        n_busy        = 1'b0;
                        n_len         = '0;
                        n_len_zero    = '0;
                        n_zero_seen   = 1'b0;
                        n_digit_found = 1'b0;
                        n_in_run      = 1'b0;
                        n_number      = '0;
                        n_last_cr     = 1'b0;
                        n_res_valid   = 1'b1;
                        n_status      = ST_TIMEOUT;
                    end
                end
            end
            CMD_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // state and result register advance together
    logic r_res_valid;
    logic [STATUS_W-1:0] r_status;
    logic [PPM_W-1:0]    r_ppm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_elapsed     <= '0;
            r_len         <= '0;
            r_len_zero    <= '0;
            r_zero_seen   <= 1'b0;
            r_digit_found <= 1'b0;
            r_in_run      <= 1'b0;
            r_number      <= '0;
            r_last_cr     <= 1'b0;
            r_res_valid   <= 1'b0;
        end else if (advance) begin
            r_res_valid <= r_in_valid && n_res_valid;
            if (r_in_valid) begin
                r_busy        <= n_busy;
                r_elapsed     <= n_elapsed;
                r_len         <= n_len;
                r_len_zero    <= n_len_zero;
                r_zero_seen   <= n_zero_seen;
                r_digit_found <= n_digit_found;
                r_in_run      <= n_in_run;
                r_number      <= n_number;
                r_last_cr     <= n_last_cr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && n_res_valid) begin
            r_status <= n_status;
            r_ppm    <= n_ppm;
        end
    end

    assign o_res.valid  = r_res_valid;
    assign o_res.status = r_status;
    assign o_res.ppm    = r_ppm;

endmodule

`default_nettype wire

// File: rtl/core/co2p_checker.sv
// Checker: port-level properties of the CO2 line parser, bound to the top level.
`default_nettype none

module co2p_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_cmd_valid,
    input wire logic                          i_cmd_ready,
    input wire logic                          i_res_valid,
    input wire logic                          i_res_ready,
    input wire logic [co2p_pkg::STATUS_W-1:0] i_res_status,
    input wire logic [co2p_pkg::PPM_W-1:0]    i_res_ppm,
    input wire logic                          i_psel,
    input wire logic                          i_penable,
    input wire logic                          i_pwrite,
    input wire logic [co2p_pkg::APB_AW-1:0]   i_paddr,
    input wire logic [co2p_pkg::APB_DW-1:0]   i_pwdata,
    input wire logic [co2p_pkg::APB_DW-1:0]   i_prdata
);
    import co2p_pkg::*;

    // a stalled result word holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_status) && $stable(i_res_ppm))
        else $error("result word changed while stalled");

    // only an ok word carries a reading
    a_ppm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status != ST_OK) |->
            (i_res_ppm == '0) && (i_res_status <= ST_TIMEOUT))
        else $error("non-ok result carries a reading");

    // a fresh result follows an accepted command word
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_cmd_valid && i_cmd_ready, 2))
        else $error("result word without a command word");

    // max_ppm written reads back
    a_cfg_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_MAX_PPM) |=>
            (i_paddr[2] != REG_MAX_PPM) ||
            (i_prdata[PPM_W-1:0] == $past(i_pwdata[PPM_W-1:0])))
        else $error("max_ppm readback mismatch");

endmodule

bind co2_ppm_line_parser co2p_checker u_co2p_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.status),
    .i_res_ppm    (o_res.ppm),
    .i_psel       (i_psel),
    .i_penable    (i_penable),
    .i_pwrite     (i_pwrite),
    .i_paddr      (i_paddr),
    .i_pwdata     (i_pwdata),
    .i_prdata     (o_prdata)
);

`default_nettype wire

// File: verif/tb_co2_ppm_line_parser.sv
// Self-checking testbench for the CO2 ppm line parser: directed table, random requests, APB setup.
module tb_co2_ppm_line_parser;
    import co2p_pkg::*;

    localparam int unsigned LINE_LIMIT         = 49;
    localparam int unsigned MIN_LINE           = 11;
    localparam int unsigned DEFAULT_TIMEOUT_MS = 3000;

    localparam int RANDOM_ITEMS   = 1500;
    localparam int N_PHASES       = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;

    // stands for a zero byte inside the directed line texts
    localparam logic [BYTE_W-1:0] NUL_MARK = "@";

    localparam logic [PPM_W-1:0] PHASE_TIMEOUT [N_PHASES] =
        '{16'd7, 16'd65535, 16'd1, 16'd40, 16'd0, 16'd3};
    localparam logic [PPM_W-1:0] PHASE_MAX_PPM [N_PHASES] =
        '{16'd500, 16'd65535, 16'd0, 16'd9999, 16'd1234, 16'd20000};

    typedef struct packed {
        t_status          st;
        logic [PPM_W-1:0] ppm;
    } t_reading;

    typedef struct {
        t_cmd              cmd;
        logic [BYTE_W-1:0] bval;
        int unsigned       reps;
        string             text;
        bit                typed;
        bit                has;
        t_reading          rd;
    } t_row;

    localparam t_reading NO_READING = '{st: ST_OK, ppm: '0};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_psel;
    logic                i_penable;
    logic                i_pwrite;
    logic [APB_AW-1:0]   i_paddr;
    logic [APB_DW-1:0]   i_pwdata;
    logic [APB_DW-1:0]   o_prdata;
    logic                o_pready;

    co2p_cmd_if cmd_bus ();
    co2p_res_if res_bus ();

    co2_ppm_line_parser #(
        .LINE_LIMIT         (LINE_LIMIT),
        .MIN_LINE           (MIN_LINE),
        .DEFAULT_TIMEOUT_MS (DEFAULT_TIMEOUT_MS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_bus),
        .o_res     (res_bus),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #5 i_clk = ~i_clk;

    // parser state as the checker sees it
    bit                   req_open;
    logic [ELAPSED_W-1:0] ms_elapsed;
    logic [5:0]           line_len;
    logic [5:0]           len_to_nul;
    bit                   nul_seen;
    bit                   digit_seen;
    bit                   in_digits;
    logic [PPM_W-1:0]     ppm_acc;
    bit                   ends_cr;
    logic [PPM_W-1:0]     cfg_timeout;
    logic [PPM_W-1:0]     cfg_max_ppm;

    t_reading due_readings [$];

    int  n_words;
    int  n_fail;
    int  n_ok;
    int  n_invalid;
    int  n_timeout;
    int  n_settings;
    int  idle_cycles;
    bit  tx_calm;
    bit  hold_req;
    t_row plan [$];

    function automatic t_reading reading(input t_status s, input logic [PPM_W-1:0] v);
        t_reading r;
        r.st  = s;
        r.ppm = v;
        return r;
    endfunction

    function automatic t_row row(input t_cmd c, input logic [BYTE_W-1:0] b, input int unsigned n,
                                 input string s, input bit typed, input bit has,
                                 input t_reading rd);
        t_row r;
        r.cmd   = c;
        r.bval  = b;
        r.reps  = n;
        r.text  = s;
        r.typed = typed;
        r.has   = has;
        r.rd    = rd;
        return r;
    endfunction

    function automatic logic [ELAPSED_W-1:0] timeout_limit();
        return (cfg_timeout == '0) ? ELAPSED_W'(DEFAULT_TIMEOUT_MS) : ELAPSED_W'(cfg_timeout);
    endfunction

    function automatic void clear_line();
        line_len   = '0;
        len_to_nul = '0;
        nul_seen   = 1'b0;
        digit_seen = 1'b0;
        in_digits  = 1'b0;
        ppm_acc    = '0;
        ends_cr    = 1'b0;
    endfunction

    // judge the finished line; a good one closes the request
    function automatic void close_line(output bit has, output t_reading rd);
        logic [5:0]       eff_len;
        bit               good;
        logic [PPM_W-1:0] v;
        eff_len = nul_seen ? len_to_nul : line_len;
        good    = (line_len != 0) && (eff_len >= MIN_LINE) && ends_cr && digit_seen;
        v       = ppm_acc;
        clear_line();
        has = good;
        rd  = NO_READING;
        if (good) begin
            req_open = 1'b0;
            rd = (v <= cfg_max_ppm) ? reading(ST_OK, v) : reading(ST_INVALID, '0);
        end
    endfunction

    function automatic void parse_word(input t_cmd c, input logic [BYTE_W-1:0] b,
                                       output bit has, output t_reading rd);
        int unsigned acc;
        has = 1'b0;
        rd  = NO_READING;
        case (c)
            CMD_START: begin
                req_open   = 1'b1;
                ms_elapsed = '0;
                clear_line();
            end
            CMD_BYTE: if (req_open) begin
                if (b == CHAR_LF) begin
                    close_line(has, rd);
                end else begin
                    if (!nul_seen) begin
                        if (b == CHAR_NUL) begin
                            nul_seen   = 1'b1;
                            len_to_nul = line_len;
                            in_digits  = 1'b0;
                        end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                            if (!digit_seen) begin
                                digit_seen = 1'b1;
                                in_digits  = 1'b1;
                                ppm_acc    = PPM_W'(b - CHAR_ZERO);
                            end else if (in_digits) begin
                                acc     = 32'(ppm_acc) * 10 + 32'(b - CHAR_ZERO);
                                ppm_acc = (acc > 32'(PPM_SAT)) ? PPM_SAT : acc[PPM_W-1:0];
                            end
                        end else begin
                            in_digits = 1'b0;
                        end
                    end
                    ends_cr  = (b == CHAR_CR);
                    line_len = line_len + 6'd1;
                    if (line_len >= LINE_LIMIT)
                        close_line(has, rd);
                end
            end
            CMD_TICK: if (req_open) begin
                if (ms_elapsed != ELAPSED_MAX)
                    ms_elapsed = ms_elapsed + 1'b1;
                if (ms_elapsed > timeout_limit()) begin
                    req_open = 1'b0;
                    clear_line();
                    has = 1'b1;
                    rd  = reading(ST_TIMEOUT, '0);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] filler();
        logic [BYTE_W-1:0] v;
        do
            v = BYTE_W'($urandom_range(1, 255));
        while (v == CHAR_LF || v == CHAR_CR || (v >= CHAR_ZERO && v <= CHAR_NINE));
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] digit();
        return BYTE_W'(CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    // offer one command word, hold it until taken, then predict its reading
    task automatic send_word(input t_cmd c, input logic [BYTE_W-1:0] b, input bit typed,
                             input bit push_typed, input t_reading typed_rd);
        int       gap;
        bit       has;
        t_reading rd;
        gap = 0;
        if ($urandom_range(0, 199) == 0)
            tx_calm = !tx_calm;
        if (!tx_calm && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= c;
        cmd_bus.rx_byte <= b;
        do
            @(posedge i_clk);
        while (!cmd_bus.ready);
        parse_word(c, b, has, rd);
        n_words++;
        if (push_typed)
            due_readings.push_back(typed_rd);
        else if (!typed && has)
            due_readings.push_back(rd);
    endtask

    // drop valid and wait for every outstanding reading
    task automatic drain_words();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (due_readings.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [PPM_W-1:0] val);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= APB_DW'(val);
        @(negedge i_clk);
        i_penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_pready);
        if (idx == REG_TIMEOUT)
            cfg_timeout = val;
        else
            cfg_max_ppm = val;
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    // one request: mostly well-formed lines with random content, some broken ones and noise
    task automatic send_random_request();
        logic [BYTE_W-1:0] line_q [$];
        int                kind;
        int                keep;
        send_word(CMD_START, BYTE_W'($urandom), 1'b0, 1'b0, NO_READING);
        repeat ($urandom_range(1, 3)) begin
            line_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                repeat ($urandom_range(0, 8)) line_q.push_back(filler());
                repeat (($urandom_range(0, 7) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5))
                    line_q.push_back(digit());
                repeat ($urandom_range(0, 5)) line_q.push_back(filler());
                if (kind < 60) begin
                    while (line_q.size() < MIN_LINE - 1)
                        line_q.push_back(" ");
                end else begin
                    // too short to pass the length check
                    keep = $urandom_range(1, 8);
                    while (line_q.size() > keep)
                        void'(line_q.pop_back());
                end
                if ($urandom_range(0, 5) == 0) begin
                    line_q.push_back(CHAR_NUL);
                    repeat ($urandom_range(0, 3)) line_q.push_back(digit());
                end
                line_q.push_back(CHAR_CR);
            end else if (kind < 78) begin
                repeat ($urandom_range(MIN_LINE, 20))
                    line_q.push_back(($urandom_range(0, 2) == 0) ? digit() : filler());
            end else if (kind < 84) begin
                repeat ($urandom_range(MIN_LINE, 20)) line_q.push_back(filler());
                line_q.push_back(CHAR_CR);
            end else if (kind < 92) begin
                // runs into the line limit, sometimes with the carriage return right on it
                repeat ($urandom_range(LINE_LIMIT - 4, LINE_LIMIT + 10))
                    line_q.push_back(($urandom_range(0, 3) == 0) ? digit() : filler());
                line_q.push_back(CHAR_CR);
            end else begin
                repeat ($urandom_range(1, 30)) line_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            if (kind < 92 || $urandom_range(0, 1) == 0)
                line_q.push_back(CHAR_LF);
            foreach (line_q[i]) begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3))
                        send_word(CMD_TICK, BYTE_W'($urandom), 1'b0, 1'b0, NO_READING);
                if ($urandom_range(0, 299) == 0)
                    send_word(CMD_NONE, BYTE_W'($urandom), 1'b0, 1'b0, NO_READING);
                if ($urandom_range(0, 399) == 0)
                    send_word(CMD_START, BYTE_W'($urandom), 1'b0, 1'b0, NO_READING);
                send_word(CMD_BYTE, line_q[i], 1'b0, 1'b0, NO_READING);
            end
        end
        if (timeout_limit() <= 64 && $urandom_range(0, 3) == 0)
            repeat (timeout_limit() + 1)
                send_word(CMD_TICK, BYTE_W'($urandom), 1'b0, 1'b0, NO_READING);
    endtask

    // receiver: random stalls in bursts, plus one long hold-off on request
    initial begin : rx_side
        int stall;
        bit calm;
        stall = 0;
        calm  = 1'b0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                res_bus.ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 299) == 0)
                    calm = !calm;
                if (stall == 0 && !calm && $urandom_range(0, 3) == 0)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
                if (stall > 0) begin
                    stall--;
                    res_bus.ready <= 1'b0;
                end else begin
                    res_bus.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : reading_check
        t_reading want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (due_readings.size() == 0) begin
                $error("unexpected reading: status %0d ppm %0d", res_bus.status, res_bus.ppm);
                n_fail++;
            end else begin
                want = due_readings.pop_front();
                if (res_bus.status !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, res_bus.status);
                    n_fail++;
                end
                if (res_bus.ppm !== want.ppm) begin
                    $error("ppm: expected %0d, got %0d", want.ppm, res_bus.ppm);
                    n_fail++;
                end
                case (want.st)
                    ST_OK:      n_ok++;
                    ST_INVALID: n_invalid++;
                    default:    n_timeout++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)
                || (i_psel && i_penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $error("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main
        int                target;
        int                pause_at;
        bit                paused;
        int unsigned       n;
        t_cmd              c;
        logic [BYTE_W-1:0] b;

        i_rst_n         = 1'b0;
        i_psel          = 1'b0;
        i_penable       = 1'b0;
        i_pwrite        = 1'b0;
        i_paddr         = '0;
        i_pwdata        = '0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.command = CMD_NONE;
        cmd_bus.rx_byte = '0;
        idle_cycles     = 0;
        n_words         = 0;
        n_fail          = 0;
        n_ok            = 0;
        n_invalid       = 0;
        n_timeout       = 0;
        n_settings      = 1;
        tx_calm         = 1'b0;
        hold_req        = 1'b0;
        cfg_timeout     = '0;
        cfg_max_ppm     = MAX_PPM_RESET;
        req_open        = 1'b0;
        ms_elapsed      = '0;
        clear_line();

        // reset values: default time limit, max_ppm 10000
        plan.push_back(row(CMD_BYTE,  "A",   2, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_TICK,  8'h00, 2, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_NONE,  8'hFF, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_START, 8'h00, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_NONE,  8'h00, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "level 00420 x\r\n", 1, 1,
                           reading(ST_OK, 16'd420)));
        plan.push_back(row(CMD_START, 8'hFF, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "level 10000\r\n", 1, 1,
                           reading(ST_OK, 16'd10000)));
        plan.push_back(row(CMD_START, 8'h00, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "level 10001\r\n", 1, 1,
                           reading(ST_INVALID, '0)));
        // empty line, short line, then a digit run that saturates
        plan.push_back(row(CMD_START, 8'h00, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "\n", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "ab 1234 x\r\n", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "99999999 xy\r\n", 1, 1,
                           reading(ST_INVALID, '0)));
        // no CR, no digit, zero byte too early, digit only after the zero byte
        plan.push_back(row(CMD_START, 8'h00, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "ppm 1234 abcd\n", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "no digits ok\r\n", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "ppm 55@67890\r\n", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "no digit here@12\r\n", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "level 99 xy@7\r\n", 1, 1,
                           reading(ST_OK, 16'd99)));
        // restart drops the partial line
        plan.push_back(row(CMD_START, 8'h00, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "ppm 3", 1, 0, NO_READING));
        plan.push_back(row(CMD_START, 8'h00, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "level 0 abcd\r\n", 1, 1,
                           reading(ST_OK, 16'd0)));
        plan.push_back(row(CMD_START, 8'h00, 1, "", 0, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "t=21.5C level 777\r\n", 0, 0, NO_READING));
        // full lines: one without CR, then a stray newline, then one ending on CR
        plan.push_back(row(CMD_START, 8'h00, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "ppm 512", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  "x",  42, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "\n", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "ppm 513", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  "x",  41, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_BYTE,  CHAR_CR, 1, "", 1, 1, reading(ST_OK, 16'd513)));
        plan.push_back(row(CMD_BYTE,  8'h00, 0, "\n", 1, 0, NO_READING));
        // zero timeout register selects the default limit
        plan.push_back(row(CMD_START, 8'h00, 1, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_TICK,  8'h00, DEFAULT_TIMEOUT_MS, "", 1, 0, NO_READING));
        plan.push_back(row(CMD_TICK,  8'hFF, 1, "", 1, 1, reading(ST_TIMEOUT, '0)));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            n = (plan[i].text.len() != 0) ? plan[i].text.len() : plan[i].reps;
            for (int k = 0; k < n; k++) begin
                if (plan[i].text.len() != 0) begin
                    c = CMD_BYTE;
                    b = plan[i].text[k];
                    if (b == NUL_MARK)
                        b = CHAR_NUL;
                end else begin
                    c = plan[i].cmd;
                    b = plan[i].bval;
                end
                send_word(c, b, plan[i].typed, plan[i].typed && plan[i].has && (k == n - 1),
                          plan[i].rd);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_words();
            write_reg(REG_TIMEOUT, PHASE_TIMEOUT[p]);
            write_reg(REG_MAX_PPM, PHASE_MAX_PPM[p]);
            n_settings++;
            // long result hold-off while words keep coming
            if (p == 0)
                hold_req = 1'b1;
            target   = n_words + RANDOM_ITEMS / N_PHASES;
            pause_at = n_words + RANDOM_ITEMS / (2 * N_PHASES);
            paused   = 1'b0;
            while (n_words < target) begin
                send_random_request();
                if (!paused && n_words >= pause_at) begin
                    drain_words();
                    paused = 1'b1;
                end
            end
        end

        drain_words();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d command words under %0d register settings, with result hold-off.",
                 n_words, n_settings);
        $display("Readings checked: %0d ok, %0d above limit, %0d timeouts.",
                 n_ok, n_invalid, n_timeout);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
